FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the SD SPI command engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

FILE: rtl/ssce_pkg.sv
// Shared types and constants of the SD SPI command engine.
package ssce_pkg;

   // Port widths
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 4;

   // Request kinds carried in req_tuser
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_RX    = 1'b1;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_CRC_EN    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_ATT   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_POLL  = 2'd2;

   // Register reset values
   localparam logic       CRC_EN_RST   = 1'b1;
   localparam logic [2:0] MAX_ATT_RST  = 3'd3;
   localparam logic [3:0] MAX_POLL_RST = 4'd9;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;

   // SD commands and frame bytes
   localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
   localparam logic [5:0] CMD_VOLT_CHECK   = 6'd8;
   localparam logic [5:0] CMD_OCR_QUERY    = 6'd58;
   localparam logic [7:0] START_BITS       = 8'h40;
   localparam logic [7:0] CRC_FIXED        = 8'h95;
   localparam logic [7:0] CRC_NONE         = 8'h01;
   localparam logic [7:0] FILL_BYTE        = 8'hFF;

   // Frame beat positions
   localparam logic [2:0] BEAT_CMD   = 3'd0;
   localparam logic [2:0] BEAT_ARG3  = 3'd1;
   localparam logic [2:0] BEAT_ARG2  = 3'd2;
   localparam logic [2:0] BEAT_ARG1  = 3'd3;
   localparam logic [2:0] BEAT_ARG0  = 3'd4;
   localparam logic [2:0] BEAT_CRC   = 3'd5;
   localparam logic [2:0] BEAT_FILL  = 3'd6;
   localparam logic [2:0] BEAT_POLL  = 3'd7;

   // Trailing response length in bytes
   localparam logic [2:0] RESP_BYTES = 3'd4;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_POLL,
      PH_READ
   } phase_type;

   typedef enum logic [1:0] {
      RUN_FRAME,
      RUN_POLL,
      RUN_DONE
   } run_kind_type;

   // One run of results handed from the core to the emitter
   typedef struct packed {
      run_kind_type kind;
      logic         wait_flag;
      logic [7:0]   cmd_byte;
      logic [31:0]  argument;
      logic [7:0]   crc_byte;
      logic [1:0]   status;
      logic [31:0]  resp;
   } run_type;

endpackage

FILE: rtl/ssce_core.sv
// Request register, command state and per-request decision logic.
`include "assert_macros.svh"

module ssce_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tuser,
   input  logic [ssce_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              csr_we,
   input  logic [ssce_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [ssce_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              emit_ready,
   output logic                              run_load,
   output ssce_pkg::run_type                 run
);

   // Request register
   logic        in_vld_ff, in_vld_in;
   logic        in_action_ff, in_action_in;
   logic [5:0]  in_cmd_ff, in_cmd_in;
   logic [31:0] in_arg_ff, in_arg_in;
   logic        in_want_ff, in_want_in;
   logic [7:0]  in_rx_ff, in_rx_in;

   // Configuration
   logic        crc_en_ff, crc_en_in;
   logic [2:0]  max_att_ff, max_att_in;
   logic [3:0]  max_poll_ff, max_poll_in;

   // Command state
   ssce_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  att_ff, att_in;
   logic [3:0]  poll_ff, poll_in;
   logic [2:0]  rbc_ff, rbc_in;
   logic [5:0]  cmd_ff, cmd_in;
   logic [31:0] arg_ff, arg_in;
   logic        want_ff, want_in;
   logic [31:0] acc_ff, acc_in;

   logic        take, consume, has_run, is_start;
   logic [3:0]  pmax;
   logic [2:0]  amax, att_inc, rbc_inc;
   logic        keep_poll, retry_tok, retry_out, bad_tok, want_read, read_done;
   logic [31:0] acc_shift;
   logic [5:0]  frame_cmd;
   logic [31:0] frame_arg;

   // Handshake: a request leaves the register once its run is handed over, or at once if it has no run
   assign is_start   = (in_action_ff == ssce_pkg::ACT_START);
   assign consume    = in_vld_ff && (!has_run || emit_ready);
   assign req_tready = !in_vld_ff || consume;
   assign take       = req_tvalid && req_tready;
   assign run_load   = in_vld_ff && has_run && emit_ready;

   always_comb begin
      in_vld_in    = take ? 1'b1 : (consume ? 1'b0 : in_vld_ff);
      in_action_in = take ? req_tuser        : in_action_ff;
      in_cmd_in    = take ? req_tdata[5:0]   : in_cmd_ff;
      in_arg_in    = take ? req_tdata[37:6]  : in_arg_ff;
      in_want_in   = take ? req_tdata[38]    : in_want_ff;
      in_rx_in     = take ? req_tdata[46:39] : in_rx_ff;
   end

   // Register writes
   always_comb begin
      crc_en_in   = crc_en_ff;
      max_att_in  = max_att_ff;
      max_poll_in = max_poll_ff;
      if (csr_we) begin
         case (csr_addr)
            ssce_pkg::REG_CRC_EN:   crc_en_in   = csr_wdata[0];
            ssce_pkg::REG_MAX_ATT:  max_att_in  = csr_wdata[2:0];
            ssce_pkg::REG_MAX_POLL: max_poll_in = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Token checks; zero budgets count as one
   assign pmax      = (max_poll_ff == 4'd0) ? 4'd1 : max_poll_ff;
   assign amax      = (max_att_ff == 3'd0) ? 3'd1 : max_att_ff;
   assign att_inc   = att_ff + 3'd1;
   assign rbc_inc   = rbc_ff + 3'd1;
   assign keep_poll = in_rx_ff[7] && (poll_ff < pmax);
   assign retry_tok = (in_rx_ff == ssce_pkg::FILL_BYTE) || in_rx_ff[3];
   assign retry_out = (att_inc >= amax);
   assign bad_tok   = (in_rx_ff > 8'd1);
   assign want_read = want_ff && ((cmd_ff == ssce_pkg::CMD_VOLT_CHECK) ||
                                  (cmd_ff == ssce_pkg::CMD_OCR_QUERY));
   assign acc_shift = {acc_ff[23:0], in_rx_ff};
   assign read_done = (rbc_inc >= ssce_pkg::RESP_BYTES);
   assign frame_cmd = is_start ? in_cmd_ff : cmd_ff;
   assign frame_arg = is_start ? in_arg_ff : arg_ff;

   // Next state
   always_comb begin
      phase_in = phase_ff;
      att_in   = att_ff;
      poll_in  = poll_ff;
      rbc_in   = rbc_ff;
      cmd_in   = cmd_ff;
      arg_in   = arg_ff;
      want_in  = want_ff;
      acc_in   = acc_ff;
      if (consume) begin
         if (is_start) begin
            cmd_in   = in_cmd_ff;
            arg_in   = in_arg_ff;
            want_in  = in_want_ff;
            att_in   = 3'd0;
            rbc_in   = 3'd0;
            acc_in   = 32'd0;
            phase_in = ssce_pkg::PH_POLL;
            poll_in  = 4'd1;
         end else begin
            case (phase_ff)
               ssce_pkg::PH_POLL: begin
                  if (keep_poll) begin
                     poll_in = poll_ff + 4'd1;
                  end else if (retry_tok) begin
                     att_in = att_inc;
                     if (retry_out) begin
                        phase_in = ssce_pkg::PH_IDLE;
                     end else begin
                        poll_in = 4'd1;
                     end
                  end else if (bad_tok) begin
                     phase_in = ssce_pkg::PH_IDLE;
                  end else if (want_read) begin
                     phase_in = ssce_pkg::PH_READ;
                     rbc_in   = 3'd0;
                     acc_in   = 32'd0;
                  end else begin
                     phase_in = ssce_pkg::PH_IDLE;
                  end
               end
               ssce_pkg::PH_READ: begin
                  acc_in = acc_shift;
                  rbc_in = rbc_inc;
                  if (read_done) begin
                     phase_in = ssce_pkg::PH_IDLE;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Run descriptor for the request in the register
   always_comb begin
      has_run       = 1'b0;
      run.kind      = ssce_pkg::RUN_POLL;
      run.wait_flag = 1'b0;
      run.cmd_byte  = ssce_pkg::START_BITS | {2'b00, frame_cmd};
      run.argument  = frame_arg;
      run.crc_byte  = (crc_en_ff || (frame_cmd == ssce_pkg::CMD_GO_IDLE) ||
                       (frame_cmd == ssce_pkg::CMD_VOLT_CHECK)) ?
                      ssce_pkg::CRC_FIXED : ssce_pkg::CRC_NONE;
      run.status    = ssce_pkg::ST_OK;
      run.resp      = 32'd0;
      if (is_start) begin
         has_run  = 1'b1;
         run.kind = ssce_pkg::RUN_FRAME;
      end else begin
         case (phase_ff)
            ssce_pkg::PH_POLL: begin
               has_run = 1'b1;
               if (keep_poll) begin
                  run.kind = ssce_pkg::RUN_POLL;
               end else if (retry_tok) begin
                  if (retry_out) begin
                     run.kind   = ssce_pkg::RUN_DONE;
                     run.status = ssce_pkg::ST_TIMEOUT;
                  end else begin
                     run.kind      = ssce_pkg::RUN_FRAME;
                     run.wait_flag = 1'b1;
                  end
               end else if (bad_tok) begin
                  run.kind   = ssce_pkg::RUN_DONE;
                  run.status = ssce_pkg::ST_INVALID;
               end else if (want_read) begin
                  run.kind = ssce_pkg::RUN_POLL;
               end else begin
                  run.kind = ssce_pkg::RUN_DONE;
               end
            end
            ssce_pkg::PH_READ: begin
               has_run = 1'b1;
               if (read_done) begin
                  run.kind = ssce_pkg::RUN_DONE;
                  run.resp = acc_shift;
               end
            end
            default: has_run = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         crc_en_ff   <= ssce_pkg::CRC_EN_RST;
         max_att_ff  <= ssce_pkg::MAX_ATT_RST;
         max_poll_ff <= ssce_pkg::MAX_POLL_RST;
         phase_ff    <= ssce_pkg::PH_IDLE;
         att_ff      <= 3'd0;
         poll_ff     <= 4'd0;
         rbc_ff      <= 3'd0;
         cmd_ff      <= 6'd0;
         arg_ff      <= 32'd0;
         want_ff     <= 1'b0;
         acc_ff      <= 32'd0;
      end else begin
         in_vld_ff   <= in_vld_in;
         crc_en_ff   <= crc_en_in;
         max_att_ff  <= max_att_in;
         max_poll_ff <= max_poll_in;
         phase_ff    <= phase_in;
         att_ff      <= att_in;
         poll_ff     <= poll_in;
         rbc_ff      <= rbc_in;
         cmd_ff      <= cmd_in;
         arg_ff      <= arg_in;
         want_ff     <= want_in;
         acc_ff      <= acc_in;
      end
   end

   // Request payload holds no control state
   always_ff @(posedge clock) begin
      in_action_ff <= in_action_in;
      in_cmd_ff    <= in_cmd_in;
      in_arg_ff    <= in_arg_in;
      in_want_ff   <= in_want_in;
      in_rx_ff     <= in_rx_in;
   end

   // A held request with pending results must stay until the emitter frees
   `ASSERT_CLK(a_hold_blocked, clock, reset,
      (in_vld_ff && has_run && !emit_ready) |=> in_vld_ff)
   // Read phase never runs past the response length
   `ASSERT_NEVER(a_rbc_range, clock, reset,
      (phase_ff == ssce_pkg::PH_READ) && (rbc_ff >= ssce_pkg::RESP_BYTES))
   // A start always leaves the engine polling
   `ASSERT_CLK(a_start_polls, clock, reset,
      (consume && is_start) |=> (phase_ff == ssce_pkg::PH_POLL) && (poll_ff == 4'd1))

endmodule

FILE: rtl/ssce_emit.sv
// Result register and sequencer that emits each run one byte exchange per beat.
`include "assert_macros.svh"

module ssce_emit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              run_load,
   input  ssce_pkg::run_type                 run,
   output logic                              emit_ready,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ssce_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   logic              busy_ff, busy_in;
   logic [2:0]        idx_ff, idx_in;
   ssce_pkg::run_type run_ff, run_in;

   logic        fire, beat_last;
   logic [7:0]  tx_byte;
   logic        capture, chip_select, wait_flag, done_res;
   logic [1:0]  status;
   logic [31:0] response_word;

   // Beat control
   assign fire       = busy_ff && rsp_tready;
   assign beat_last  = (run_ff.kind != ssce_pkg::RUN_FRAME) ||
                       (idx_ff == ssce_pkg::BEAT_POLL);
   assign emit_ready = !busy_ff || (rsp_tready && beat_last);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      run_in  = run_ff;
      if (run_load) begin
         busy_in = 1'b1;
         idx_in  = 3'd0;
         run_in  = run;
      end else if (fire) begin
         if (beat_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   // Beat contents
   always_comb begin
      tx_byte       = ssce_pkg::FILL_BYTE;
      capture       = 1'b0;
      chip_select   = 1'b0;
      wait_flag     = 1'b0;
      done_res      = 1'b0;
      status        = ssce_pkg::ST_OK;
      response_word = 32'd0;
      case (run_ff.kind)
         ssce_pkg::RUN_FRAME: begin
            case (idx_ff)
               ssce_pkg::BEAT_CMD: begin
                  tx_byte   = run_ff.cmd_byte;
                  wait_flag = run_ff.wait_flag;
               end
               ssce_pkg::BEAT_ARG3: tx_byte = run_ff.argument[31:24];
               ssce_pkg::BEAT_ARG2: tx_byte = run_ff.argument[23:16];
               ssce_pkg::BEAT_ARG1: tx_byte = run_ff.argument[15:8];
               ssce_pkg::BEAT_ARG0: tx_byte = run_ff.argument[7:0];
               ssce_pkg::BEAT_CRC:  tx_byte = run_ff.crc_byte;
               ssce_pkg::BEAT_FILL: tx_byte = ssce_pkg::FILL_BYTE;
               default:             capture = 1'b1;
            endcase
         end
         ssce_pkg::RUN_POLL: capture = 1'b1;
         ssce_pkg::RUN_DONE: begin
            chip_select   = 1'b1;
            done_res      = 1'b1;
            status        = run_ff.status;
            response_word = run_ff.resp;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = beat_last;
   assign rsp_tuser  = done_res;
   assign rsp_tdata  = {3'b000, response_word, status, wait_flag, chip_select,
                        capture, tx_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

   // A new run is only taken when the current one is finishing or absent
   `ASSERT_CLK(a_load_when_free, clock, reset, run_load |-> emit_ready)
   // Single-beat runs never advance the beat index
   `ASSERT_NEVER(a_idx_single, clock, reset,
      busy_ff && (run_ff.kind != ssce_pkg::RUN_FRAME) && (idx_ff != 3'd0))
   // A taken middle beat of a frame moves to the next byte
   `ASSERT_CLK(a_idx_step, clock, reset,
      (fire && !beat_last && !run_load) |=> (idx_ff == $past(idx_ff) + 3'd1))
   // A status report always closes its run
   `ASSERT_CLK(a_done_last, clock, reset, (rsp_tvalid && rsp_tuser) |-> rsp_tlast)

endmodule

FILE: rtl/sd_spi_command_engine.sv
// Top level of the SD SPI-mode command engine.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser action, tdata command fields or rx byte
//   rsp      out  rsp_tvalid/rsp_tready  tuser done, tdata byte exchange, tlast end of run
//   csr      in   csr_we                 csr_addr register index, csr_wdata value
//
// A request is decided from the request register and the command state; its run enters
// the result register when the emitter is ready. A start or an in-budget retry token
// yields eight result beats, every other request one or none, one beat per cycle while
// rsp_tready is high. A new request is taken every cycle while each causes a single beat
// and rsp_tready stays high. Synchronous active-high reset clears the control state and
// loads the register defaults; a stalled rsp side holds its beat unchanged.

module sd_spi_command_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tuser,  // action
   // cmd_index[5:0], argument[37:6], want_response[38], rx_byte[46:39], zero
   input  logic [ssce_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic                              rsp_tuser,  // done_res
   // tx_byte[7:0], capture[8], chip_select[9], wait_before_retry[10],
   // status[12:11], response_word[44:13], zero
   output logic [ssce_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [ssce_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [ssce_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic              emit_ready;
   logic              run_load;
   ssce_pkg::run_type run;

   ssce_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .emit_ready (emit_ready),
      .run_load   (run_load),
      .run        (run)
   );

   ssce_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .run_load   (run_load),
      .run        (run),
      .emit_ready (emit_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: sim/tb.sv
// Self-checking stream testbench for the SD SPI command engine: directed and random requests.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ssce_pkg::*;

   localparam int RAND_ITEMS   = 350;
   localparam int NUM_PHASES   = 6;
   localparam int DRAIN_CYCLES = 16;

   // one request as the sender sees it
   typedef struct {
      logic        action;
      logic [5:0]  cmd;
      logic [31:0] arg;
      logic        want;
      logic [7:0]  rx;
   } req_item_type;

   // one expected result beat
   typedef struct {
      logic [7:0]  tx;
      logic        capture;
      logic        cs;
      logic        wait_retry;
      logic        done;
      logic [1:0]  status;
      logic [31:0] resp;
      logic        last;
   } beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sd_spi_command_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // engine shadow: configuration and command state
   logic        cfg_crc  = CRC_EN_RST;
   logic [2:0]  cfg_att  = MAX_ATT_RST;
   logic [3:0]  cfg_poll = MAX_POLL_RST;
   phase_type   eng_phase = PH_IDLE;
   logic [2:0]  att_cnt = '0;
   logic [3:0]  poll_cnt = '0;
   logic [2:0]  rbyte_cnt = '0;
   logic [5:0]  l_cmd = '0;
   logic [31:0] l_arg = '0;
   logic        l_want = 1'b0;
   logic [31:0] resp_acc = '0;

   beat_type     expected_beats[$];
   req_item_type pending_reqs[$];
   req_item_type cur_req;
   int        err_count = 0;
   int        queued_items = 0;
   int        cut_left = -1;
   int        gap_left = 0;
   int        burst_left = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_v);
      $display("tb: mismatch in %s: got %0h, expected %0h at %0t", what, got, exp_v,
               $realtime);
      err_count++;
   endtask

   task automatic add_beat(input logic [7:0] tx, input logic cap, input logic cs,
                           input logic wt, input logic dn, input logic [1:0] st,
                           input logic [31:0] rsp);
      beat_type b;
      b.tx = tx;
      b.capture = cap;
      b.cs = cs;
      b.wait_retry = wt;
      b.done = dn;
      b.status = st;
      b.resp = rsp;
      b.last = 1'b0;
      expected_beats.push_back(b);
   endtask

   // command frame plus the first poll byte
   task automatic add_frame(input logic wt);
      logic [7:0] crc;
      crc = (cfg_crc || l_cmd == CMD_GO_IDLE || l_cmd == CMD_VOLT_CHECK) ?
            CRC_FIXED : CRC_NONE;
      add_beat(START_BITS | {2'b00, l_cmd}, 1'b0, 1'b0, wt, 1'b0, ST_OK, '0);
      add_beat(l_arg[31:24], 1'b0, 1'b0, 1'b0, 1'b0, ST_OK, '0);
      add_beat(l_arg[23:16], 1'b0, 1'b0, 1'b0, 1'b0, ST_OK, '0);
      add_beat(l_arg[15:8], 1'b0, 1'b0, 1'b0, 1'b0, ST_OK, '0);
      add_beat(l_arg[7:0], 1'b0, 1'b0, 1'b0, 1'b0, ST_OK, '0);
      add_beat(crc, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK, '0);
      add_beat(FILL_BYTE, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK, '0);
      add_beat(FILL_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK, '0);
      eng_phase = PH_POLL;
      poll_cnt = 4'd1;
   endtask

   task automatic add_done(input logic [1:0] st, input logic [31:0] rsp);
      add_beat(FILL_BYTE, 1'b0, 1'b1, 1'b0, 1'b1, st, rsp);
      eng_phase = PH_IDLE;
   endtask

   // expected beats for one accepted request
   task automatic predict_exchange(input req_item_type it);
      int         n0;
      logic [3:0] pmax;
      logic [2:0] amax;
      n0 = expected_beats.size();
      pmax = (cfg_poll == 4'd0) ? 4'd1 : cfg_poll;
      amax = (cfg_att == 3'd0) ? 3'd1 : cfg_att;
      if (it.action == ACT_START) begin
         l_cmd = it.cmd;
         l_arg = it.arg;
         l_want = it.want;
         att_cnt = '0;
         rbyte_cnt = '0;
         resp_acc = '0;
         add_frame(1'b0);
      end else if (eng_phase == PH_POLL) begin
         if (it.rx[7] && poll_cnt < pmax) begin
            poll_cnt = poll_cnt + 4'd1;
            add_beat(FILL_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK, '0);
         end else if (it.rx == FILL_BYTE || it.rx[3]) begin
            att_cnt = att_cnt + 3'd1;
            if (att_cnt >= amax) add_done(ST_TIMEOUT, '0);
            else add_frame(1'b1);
         end else if (it.rx > 8'd1) begin
            add_done(ST_INVALID, '0);
         end else if (l_want && (l_cmd == CMD_VOLT_CHECK || l_cmd == CMD_OCR_QUERY)) begin
            eng_phase = PH_READ;
            rbyte_cnt = '0;
            resp_acc = '0;
            add_beat(FILL_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK, '0);
         end else begin
            add_done(ST_OK, '0);
         end
      end else if (eng_phase == PH_READ) begin
         resp_acc = {resp_acc[23:0], it.rx};
         rbyte_cnt = rbyte_cnt + 3'd1;
         if (rbyte_cnt >= RESP_BYTES) add_done(ST_OK, resp_acc);
         else add_beat(FILL_BYTE, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK, '0);
      end
      if (expected_beats.size() > n0) expected_beats[expected_beats.size()-1].last = 1'b1;
   endtask

   // unused fields of each request carry random bits
   task automatic push_start(input logic [5:0] cmd, input logic [31:0] arg, input logic want);
      req_item_type it;
      it.action = ACT_START;
      it.cmd = cmd;
      it.arg = arg;
      it.want = want;
      it.rx = 8'($urandom());
      pending_reqs.push_back(it);
      queued_items++;
   endtask

   task automatic push_rx(input logic [7:0] rx);
      req_item_type it;
      it.action = ACT_RX;
      it.cmd = 6'($urandom());
      it.arg = $urandom();
      it.want = 1'($urandom());
      it.rx = rx;
      pending_reqs.push_back(it);
      queued_items++;
   endtask

   // countdown for commands that get abandoned part way
   function automatic bit go_on();
      if (cut_left < 0) return 1'b1;
      if (cut_left == 0) return 1'b0;
      cut_left--;
      return 1'b1;
   endfunction

   // one well-formed command exchange with random content and outcome
   task automatic plan_command();
      int         pmax;
      int         amax;
      int         tries;
      int         k;
      int         outcome;
      bit         spent;
      logic [5:0] cmd;
      logic       want;
      logic [7:0] tok;
      pmax = (cfg_poll == 4'd0) ? 1 : int'(cfg_poll);
      amax = (cfg_att == 3'd0) ? 1 : int'(cfg_att);
      case ($urandom_range(0, 9))
         0, 1, 2: cmd = CMD_VOLT_CHECK;
         3, 4: cmd = CMD_OCR_QUERY;
         5: cmd = CMD_GO_IDLE;
         default: cmd = 6'($urandom_range(0, 63));
      endcase
      want = ($urandom_range(0, 3) != 0);
      cut_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 8)) : -1;
      push_start(cmd, $urandom(), want);
      tries = 0;
      forever begin
         k = ($urandom_range(0, 3) == 0) ? pmax - 1 : int'($urandom_range(0, pmax - 1));
         repeat (k) begin
            if (!go_on()) return;
            push_rx(8'($urandom_range(128, 255)));
         end
         spent = (k == pmax - 1);
         outcome = $urandom_range(0, 9);
         if (!go_on()) return;
         if (outcome < 4) begin
            // retry token; all-ones or high bit only once the poll budget is gone
            tok = {1'b0, 7'($urandom())};
            tok[3] = 1'b1;
            if (spent && $urandom_range(0, 1) == 1)
               tok = ($urandom_range(0, 1) == 1) ? FILL_BYTE : (tok | 8'h80);
            push_rx(tok);
            tries++;
            if (tries >= amax) return;
         end else if (outcome == 4) begin
            tok = {1'b0, 7'($urandom())};
            tok[3] = 1'b0;
            if (tok < 8'd2) tok = tok | 8'h02;
            if (spent && $urandom_range(0, 1) == 1) tok[7] = 1'b1;
            push_rx(tok);
            return;
         end else begin
            push_rx(8'($urandom_range(0, 1)));
            if (want && (cmd == CMD_VOLT_CHECK || cmd == CMD_OCR_QUERY)) begin
               repeat (4) begin
                  if (!go_on()) return;
                  push_rx(8'($urandom()));
               end
            end
            return;
         end
      end
   endtask

   task automatic write_regs(input logic [3:0] crc, input logic [3:0] att,
                             input logic [3:0] poll);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= REG_CRC_EN;
      csr_wdata <= crc;
      @(posedge clock);
      csr_addr <= REG_MAX_ATT;
      csr_wdata <= att;
      @(posedge clock);
      csr_addr <= REG_MAX_POLL;
      csr_wdata <= poll;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_crc = crc[0];
      cfg_att = att[2:0];
      cfg_poll = poll;
   endtask

   // wait for every request taken and every result back, then let the engine settle
   task automatic drain();
      while (pending_reqs.size() != 0 || req_tvalid || expected_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // request driver: bursts with random gaps
   always @(posedge clock) begin
      logic nxt_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         nxt_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_exchange(cur_req);
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               req_tuser <= cur_req.action;
               req_tdata <= {1'b0, cur_req.rx, cur_req.want, cur_req.arg, cur_req.cmd};
               nxt_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 16);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
               end
            end
         end
         req_tvalid <= nxt_valid;
      end
   end

   // result monitor and receiver stall pattern
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      beat_type e;
      logic  nxt_ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[31:0], '0);
            end else begin
               e = expected_beats.pop_front();
               if (rsp_tdata[7:0] !== e.tx) report_mismatch("tx_byte", rsp_tdata[7:0], e.tx);
               if (rsp_tdata[8] !== e.capture)
                  report_mismatch("capture", rsp_tdata[8], e.capture);
               if (rsp_tdata[9] !== e.cs) report_mismatch("chip_select", rsp_tdata[9], e.cs);
               if (rsp_tdata[10] !== e.wait_retry)
                  report_mismatch("wait_before_retry", rsp_tdata[10], e.wait_retry);
               if (rsp_tdata[12:11] !== e.status)
                  report_mismatch("status", rsp_tdata[12:11], e.status);
               if (rsp_tdata[44:13] !== e.resp)
                  report_mismatch("response_word", rsp_tdata[44:13], e.resp);
               if (rsp_tdata[47:45] !== 3'b000)
                  report_mismatch("tdata padding", rsp_tdata[47:45], '0);
               if (rsp_tuser !== e.done) report_mismatch("done_res", rsp_tuser, e.done);
               if (rsp_tlast !== e.last) report_mismatch("last", rsp_tlast, e.last);
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (stall_mode)
            0: nxt_ready = 1'b1;
            1: nxt_ready = 1'($urandom_range(0, 1));
            2: nxt_ready = ($urandom_range(0, 3) == 0);
            default: begin
               if (hold_left > 0) begin
                  hold_left--;
                  nxt_ready = 1'b0;
               end else begin
                  nxt_ready = 1'b1;
                  if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(1, 8);
               end
            end
         endcase
         rsp_tready <= nxt_ready;
      end
   end

   // stimulus sequence
   initial begin
      int p;
      int base;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: idle byte, ok, invalid, read with poll, retry then read, abandon
      push_rx(8'h00);
      push_start(CMD_GO_IDLE, 32'h0000_0000, 1'b0);
      push_rx(8'h01);
      push_start(6'd63, 32'hFFFF_FFFF, 1'b1);
      push_rx(8'h05);
      push_start(CMD_VOLT_CHECK, 32'h0000_01AA, 1'b1);
      push_rx(8'h80);
      push_rx(8'h01);
      push_rx(8'h00);
      push_rx(8'h00);
      push_rx(8'h01);
      push_rx(8'hAA);
      push_start(CMD_OCR_QUERY, 32'h8000_0001, 1'b1);
      push_rx(8'h08);
      push_rx(8'h00);
      push_rx(8'hFF);
      push_rx(8'h80);
      push_rx(8'h00);
      push_rx(8'h7F);
      push_start(6'd1, 32'h5A5A_A5A5, 1'b0);
      push_rx(8'h90);
      push_start(6'd55, 32'h0000_FFFF, 1'b1);
      push_rx(8'h00);
      drain();

      // zero budgets act as one; CRC off
      write_regs(4'd0, 4'd0, 4'd0);
      push_start(6'd5, 32'h1234_5678, 1'b0);
      push_rx(8'h88);
      push_start(CMD_GO_IDLE, 32'h0, 1'b1);
      push_rx(8'h82);
      push_start(CMD_VOLT_CHECK, 32'hFFFF_0000, 1'b0);
      push_rx(8'h00);

      // random phases over several register settings
      base = queued_items;
      for (p = 0; p < NUM_PHASES; p++) begin
         drain();
         case (p)
            0: write_regs(4'd1, 4'd3, 4'd9);
            1: write_regs(4'd0, 4'd1, 4'd1);
            2: write_regs(4'd1, 4'd7, 4'd15);
            3: write_regs(4'd0, 4'd2, 4'd4);
            4: write_regs(4'd1, 4'd7, 4'd1);
            default: write_regs(4'($urandom()), 4'($urandom()), 4'($urandom()));
         endcase
         while (queued_items < base + (p + 1) * RAND_ITEMS / NUM_PHASES) begin
            case ($urandom_range(0, 19))
               0: begin
                  if ($urandom_range(0, 1) == 1) push_rx(8'($urandom()));
                  else push_start(6'($urandom()), $urandom(), 1'($urandom()));
               end
               1: push_rx(8'($urandom()));
               default: plan_command();
            endcase
         end
      end
      drain();

      if (err_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // run limit
   initial begin
      #1000000;
      $display("tb: failure");
      $finish;
   end

endmodule
